@@ rtl/duc_pkg.sv @@
// ----------------------------------------------------------------------------
// duc_pkg
// Shared constants, register indexes and the digit decoder for the debounced
// up/down counter with three-digit seven-segment scan.
// ----------------------------------------------------------------------------
package duc_pkg;

   localparam int COUNT_W   = 10;
   localparam int FILTER_W  = 8;
   localparam int HOLD_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [COUNT_W-1:0]  COUNT_MAX        = 10'd999;
   localparam logic [FILTER_W-1:0] FILTER_RESET     = 8'd250;
   localparam logic [HOLD_W-1:0]   HOLD_RESET       = 16'd3;
   localparam logic [COUNT_W-1:0]  START_RESET      = 10'd0;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIGIT_HOLD    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COUNT   = 2'd2;

   // scan position
   localparam logic [1:0] DIGIT_HUNDREDS = 2'd0;
   localparam logic [1:0] DIGIT_TENS     = 2'd1;
   localparam logic [1:0] DIGIT_UNITS    = 2'd2;

   // active-low digit enables
   localparam logic [2:0] EN_HUNDREDS = 3'b011;
   localparam logic [2:0] EN_TENS     = 3'b101;
   localparam logic [2:0] EN_UNITS    = 3'b110;
   localparam logic [2:0] EN_NONE     = 3'b111;

   localparam logic [7:0] SEG_BLANK = 8'hFF;

   // active-low segment pattern, decimal point off
   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0:    code = 8'b1100_0000;
         4'd1:    code = 8'b1111_1001;
         4'd2:    code = 8'b1010_0100;
         4'd3:    code = 8'b1011_0000;
         4'd4:    code = 8'b1001_1001;
         4'd5:    code = 8'b1001_0010;
         4'd6:    code = 8'b1000_0010;
         4'd7:    code = 8'b1111_1000;
         4'd8:    code = 8'b1000_0000;
         4'd9:    code = 8'b1001_0000;
         default: code = SEG_BLANK;
      endcase
      return code;
   endfunction

endpackage

@@ rtl/debounced_updown_counter_display.sv @@
// ----------------------------------------------------------------------------
// debounced_updown_counter_display
// Debounced up/down 0..999 counter driving a three-digit multiplexed
// seven-segment display, one sample tick per transaction.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake           payload
//  req      in         req_valid/req_stall up_button_n, down_button_n
//  rsp      out        rsp_valid/rsp_stall segments_n, digit_enable_n,
//                                          count_value, save_strobe
//  csr      in         csr_valid/csr_ready csr_index, csr_data
//
//  One tick per cycle sustained while rsp is not stalled; a tick passes the
//  input register, then the result register. The counter state is updated
//  as a tick moves from the input register into the result register.
//  Reset (synchronous) restores the register defaults and the state derived
//  from them. csr_ready is always high; writes are expected only while idle.
//  A stalled result holds the input register, which then stalls req.
//
module debounced_updown_counter_display
   import duc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_up_button_n,
   input  logic                 req_down_button_n,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_segments_n,
   output logic [2:0]           rsp_digit_enable_n,
   output logic [COUNT_W-1:0]   rsp_count_value,
   output logic                 rsp_save_strobe,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [FILTER_W-1:0] filter_len_ff;
   logic [HOLD_W-1:0]   digit_hold_ff;
   logic                csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_len_ff <= FILTER_RESET;
         digit_hold_ff <= HOLD_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_FILTER_LENGTH) begin
            filter_len_ff <= csr_data[FILTER_W-1:0];
         end
         if (csr_index == CSR_DIGIT_HOLD) begin
            digit_hold_ff <= csr_data[HOLD_W-1:0];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------------
   logic in_valid_ff;
   logic in_up_n_ff;
   logic in_down_n_ff;
   logic advance;
   logic req_take;

   // tick moves on when the result register is empty or being drained
   assign advance   = in_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_take || (in_valid_ff && !advance);
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_up_n_ff   <= req_up_button_n;
         in_down_n_ff <= req_down_button_n;
      end
   end

   // ------------------------------------------------------------------------
   // Counter and debounce state
   // ------------------------------------------------------------------------
   logic [COUNT_W-1:0]  count_ff,      count_in;
   logic [FILTER_W-1:0] up_filter_ff,  up_filter_in;
   logic [FILTER_W-1:0] dn_filter_ff,  dn_filter_in;
   logic                up_wait_ff,    up_wait_in;
   logic                dn_wait_ff,    dn_wait_in;
   logic [1:0]          digit_idx_ff,  digit_idx_in;
   logic [HOLD_W-1:0]   hold_cnt_ff,   hold_cnt_in;
   logic [7:0]          shown_seg_ff,  shown_seg_in;
   logic [2:0]          shown_en_ff,   shown_en_in;
   logic                saved;

   logic                up_pressed;
   logic                dn_pressed;
   logic                busy;

   // digit split of the new count: multiply by reciprocal, then fix up
   logic [15:0]         hund_prod;
   logic [3:0]          hund;
   logic [COUNT_W-1:0]  hund_x100;
   logic [COUNT_W-1:0]  rem_full;
   logic [6:0]          rem;
   logic [14:0]         tens_prod;
   logic [3:0]          tens;
   logic [6:0]          tens_x10;
   logic [6:0]          units_full;
   logic [3:0]          units;
   logic [3:0]          digit_sel;
   logic [HOLD_W-1:0]   hold_eff;
   logic [HOLD_W-1:0]   hold_inc;

   assign up_pressed = !in_up_n_ff;
   assign dn_pressed = !in_down_n_ff;

   always_comb begin
      count_in     = count_ff;
      up_filter_in = up_filter_ff;
      dn_filter_in = dn_filter_ff;
      up_wait_in   = up_wait_ff;
      dn_wait_in   = dn_wait_ff;
      busy         = 1'b0;
      saved        = 1'b0;

      if (dn_wait_ff) begin
         // a pending down press blocks the up button entirely
         if (dn_pressed) begin
            busy = 1'b1;
         end else begin
            count_in     = (count_ff == '0) ? COUNT_MAX : count_ff - 1'b1;
            dn_filter_in = filter_len_ff;
            dn_wait_in   = 1'b0;
            saved        = 1'b1;
         end
      end else begin
         if (up_wait_ff) begin
            if (up_pressed) begin
               busy = 1'b1;
            end else begin
               count_in     = (count_ff >= COUNT_MAX) ? '0 : count_ff + 1'b1;
               up_filter_in = filter_len_ff;
               up_wait_in   = 1'b0;
               saved        = 1'b1;
            end
         end else if (up_pressed) begin
            // filter keeps its value across releases
            up_filter_in = up_filter_ff - 1'b1;
            if (up_filter_in == '0) begin
               up_wait_in = 1'b1;
            end
            busy = 1'b1;
         end

         if (!busy && dn_pressed) begin
            dn_filter_in = dn_filter_ff - 1'b1;
            if (dn_filter_in == '0) begin
               dn_wait_in = 1'b1;
            end
            busy = 1'b1;
         end
      end
   end

   // floor(v/100) = (v*41)>>12 and floor(r/10) = (r*205)>>11 hold over range
   always_comb begin
      hund_prod  = 16'(count_in) * 16'd41;
      hund       = hund_prod[15:12];
      hund_x100  = COUNT_W'(hund) * 10'd100;
      rem_full   = count_in - hund_x100;
      rem        = rem_full[6:0];
      tens_prod  = 15'(rem) * 15'd205;
      tens       = tens_prod[14:11];
      tens_x10   = 7'(tens) * 7'd10;
      units_full = rem - tens_x10;
      units      = units_full[3:0];
   end

   // display scan runs only on ticks where no button is busy
   always_comb begin
      digit_idx_in = digit_idx_ff;
      hold_cnt_in  = hold_cnt_ff;
      shown_seg_in = shown_seg_ff;
      shown_en_in  = shown_en_ff;
      hold_eff     = (digit_hold_ff == '0) ? HOLD_W'(1) : digit_hold_ff;
      hold_inc     = hold_cnt_ff + 1'b1;

      case (digit_idx_ff)
         DIGIT_TENS: begin
            digit_sel = tens;
         end
         DIGIT_UNITS: begin
            digit_sel = units;
         end
         default: begin
            digit_sel = hund;
         end
      endcase

      if (!busy) begin
         case (digit_idx_ff)
            DIGIT_TENS:  shown_en_in = EN_TENS;
            DIGIT_UNITS: shown_en_in = EN_UNITS;
            default:     shown_en_in = EN_HUNDREDS;
         endcase
         shown_seg_in = seg_code(digit_sel);
         hold_cnt_in  = hold_inc;
         if (hold_inc >= hold_eff) begin
            hold_cnt_in  = '0;
            digit_idx_in = (digit_idx_ff >= DIGIT_UNITS) ? DIGIT_HUNDREDS
                                                         : digit_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= START_RESET;
         up_filter_ff <= FILTER_RESET;
         dn_filter_ff <= FILTER_RESET;
         up_wait_ff   <= 1'b0;
         dn_wait_ff   <= 1'b0;
         digit_idx_ff <= DIGIT_HUNDREDS;
         hold_cnt_ff  <= '0;
         shown_seg_ff <= SEG_BLANK;
         shown_en_ff  <= EN_NONE;
      end else if (csr_write) begin
         // register writes also reload the state they seed
         if (csr_index == CSR_FILTER_LENGTH) begin
            up_filter_ff <= csr_data[FILTER_W-1:0];
            dn_filter_ff <= csr_data[FILTER_W-1:0];
         end
         if (csr_index == CSR_START_COUNT) begin
            count_ff <= (csr_data[COUNT_W-1:0] > COUNT_MAX) ? '0
                                                            : csr_data[COUNT_W-1:0];
         end
      end else if (advance) begin
         count_ff     <= count_in;
         up_filter_ff <= up_filter_in;
         dn_filter_ff <= dn_filter_in;
         up_wait_ff   <= up_wait_in;
         dn_wait_ff   <= dn_wait_in;
         digit_idx_ff <= digit_idx_in;
         hold_cnt_ff  <= hold_cnt_in;
         shown_seg_ff <= shown_seg_in;
         shown_en_ff  <= shown_en_in;
      end
   end

   // ------------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------------
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_segments_n     <= shown_seg_in;
         rsp_digit_enable_n <= shown_en_in;
         rsp_count_value    <= count_in;
         rsp_save_strobe    <= saved;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
`ifndef SYNTH
   // both buttons can never be waiting for release at once
   a_single_wait: assert property (@(posedge clock) disable iff (reset)
      !(up_wait_ff && dn_wait_ff))
      else $error("both buttons waiting for release");

   // scan never reaches the unused fourth position
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      digit_idx_ff != 2'd3)
      else $error("digit index out of range");

   // every reported count stays within 0..999
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count_value <= COUNT_MAX)
      else $error("count out of range");

   // a save means the count moved on a tick that reached the result register
   a_save_moves: assert property (@(posedge clock) disable iff (reset)
      (advance && saved) |=> (rsp_count_value != $past(count_ff)))
      else $error("save strobe without a count change");
`endif

endmodule

@@ verif/debounced_updown_counter_display_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_updown_counter_display_tb
// Self-checking bench for the debounced up/down counter with display scan.
// Button samples go in through the req channel. A local copy of the counter,
// filter and scan state works out every result tick, and the rsp channel is
// compared field by field in order. Several register settings are used,
// including the extremes, with random idling on both sides.
// ----------------------------------------------------------------------------
module debounced_updown_counter_display_tb;
   import duc_pkg::*;

   // write to this index must be ignored by the block
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic up_n;
      logic dn_n;
   } button_tick_type;

   typedef struct packed {
      logic [7:0]         segments_n;
      logic [2:0]         digit_enable_n;
      logic [COUNT_W-1:0] count_value;
      logic               save_strobe;
   } display_out_type;

   logic                 clock;
   logic                 reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_up_button_n = 1'b1;
   logic                 req_down_button_n = 1'b1;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [7:0]           rsp_segments_n;
   logic [2:0]           rsp_digit_enable_n;
   logic [COUNT_W-1:0]   rsp_count_value;
   logic                 rsp_save_strobe;

   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   debounced_updown_counter_display u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_up_button_n    (req_up_button_n),
      .req_down_button_n  (req_down_button_n),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_segments_n     (rsp_segments_n),
      .rsp_digit_enable_n (rsp_digit_enable_n),
      .rsp_count_value    (rsp_count_value),
      .rsp_save_strobe    (rsp_save_strobe),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // ------------------------------------------------------------------
   // Expected behavior: register copies and counter/display state
   // ------------------------------------------------------------------
   logic [FILTER_W-1:0] cfg_filter_len;
   logic [HOLD_W-1:0]   cfg_hold;
   logic [COUNT_W-1:0]  cfg_start;

   logic [COUNT_W-1:0]  count_q;
   logic [FILTER_W-1:0] up_filter_q;
   logic [FILTER_W-1:0] dn_filter_q;
   logic                up_wait_q;
   logic                dn_wait_q;
   logic [1:0]          digit_q;
   logic [HOLD_W-1:0]   hold_q;
   logic [7:0]          shown_seg_q;
   logic [2:0]          shown_en_q;

   logic [7:0]          seg_lut [0:9];

   button_tick_type     button_ticks [$];      // waiting to be driven
   display_out_type     expected_display [$];  // one per accepted transaction
   int                  mismatch_count = 0;

   // handshake bookkeeping shared by driver and monitor
   logic                req_taken = 1'b0;
   button_tick_type     next_tick;
   int                  send_idle_pct = 8;
   int                  recv_idle_pct = 59;
   logic                hold_off_req = 1'b0;
   int                  hold_off_left = 0;

   // One sample tick. Down release pending shadows everything else; up has
   // priority over down otherwise. A tick that touches a filter or waits on a
   // held button is busy and freezes the display outputs.
   function automatic display_out_type step_counter_display(input logic up_n,
                                                            input logic dn_n);
      display_out_type    r;
      logic               busy;
      logic               stepped;
      logic [COUNT_W-1:0] v;
      logic [3:0]         d;
      logic [HOLD_W-1:0]  hold_lim;

      busy    = 1'b0;
      stepped = 1'b0;

      if (dn_wait_q) begin
         if (!dn_n) begin
            busy = 1'b1;
         end else begin
            count_q     = (count_q == '0) ? COUNT_MAX : count_q - 10'd1;
            dn_filter_q = cfg_filter_len;
            dn_wait_q   = 1'b0;
            stepped     = 1'b1;
         end
      end else begin
         if (up_wait_q) begin
            if (!up_n) begin
               busy = 1'b1;
            end else begin
               count_q     = (count_q >= COUNT_MAX) ? '0 : count_q + 10'd1;
               up_filter_q = cfg_filter_len;
               up_wait_q   = 1'b0;
               stepped     = 1'b1;
            end
         end else if (!up_n) begin
            // filter wraps at 8 bits, so a zero length means 256 samples
            up_filter_q = up_filter_q - 8'd1;
            if (up_filter_q == '0) up_wait_q = 1'b1;
            busy = 1'b1;
         end

         // up release and a down sample can share one tick
         if (!busy && !dn_n) begin
            dn_filter_q = dn_filter_q - 8'd1;
            if (dn_filter_q == '0) dn_wait_q = 1'b1;
            busy = 1'b1;
         end
      end

      if (!busy) begin
         v = (count_q > COUNT_MAX) ? '0 : count_q;
         if (digit_q == DIGIT_TENS) begin
            d          = 4'((v / 10'd10) % 10'd10);
            shown_en_q = EN_TENS;
         end else if (digit_q == DIGIT_UNITS) begin
            d          = 4'(v % 10'd10);
            shown_en_q = EN_UNITS;
         end else begin
            d          = 4'(v / 10'd100);
            shown_en_q = EN_HUNDREDS;
         end
         shown_seg_q = seg_lut[d];

         // zero hold acts as one; >= catches a hold lowered mid-count
         hold_q   = hold_q + 16'd1;
         hold_lim = (cfg_hold == '0) ? 16'd1 : cfg_hold;
         if (hold_q >= hold_lim) begin
            hold_q  = '0;
            digit_q = (digit_q >= DIGIT_UNITS) ? DIGIT_HUNDREDS : digit_q + 2'd1;
         end
      end

      r.segments_n     = shown_seg_q;
      r.digit_enable_n = shown_en_q;
      r.count_value    = count_q;
      r.save_strobe    = stepped;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Driver: launches the next button tick once the current transaction
   // is taken; a stalled payload stays put.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (button_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_tick         = button_ticks.pop_front();
            req_valid         <= 1'b1;
            req_up_button_n   <= next_tick.up_n;
            req_down_button_n <= next_tick.dn_n;
         end else begin
            // idle: junk on the buttons, it must be ignored
            req_valid         <= 1'b0;
            req_up_button_n   <= 1'($urandom_range(1));
            req_down_button_n <= 1'($urandom_range(1));
         end
      end
   end

   // Receiver back-pressure: random stall plus an occasional long hold-off
   always @(negedge clock) begin
      if (hold_off_req) begin
         hold_off_left = 40;
         hold_off_req  = 1'b0;
      end
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_stall     <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: predicts on every accepted req transaction, then checks
   // every accepted rsp transaction against the oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      display_out_type want;
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken)
         expected_display.push_back(step_counter_display(req_up_button_n,
                                                         req_down_button_n));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_display.size() == 0) begin
            $error("unexpected rsp transaction: seg %h en %b count %0d save %b",
                   rsp_segments_n, rsp_digit_enable_n, rsp_count_value,
                   rsp_save_strobe);
            mismatch_count++;
         end else begin
            want = expected_display.pop_front();
            if (rsp_segments_n !== want.segments_n) begin
               $error("segments_n: expected %h, got %h",
                      want.segments_n, rsp_segments_n);
               mismatch_count++;
            end
            if (rsp_digit_enable_n !== want.digit_enable_n) begin
               $error("digit_enable_n: expected %b, got %b",
                      want.digit_enable_n, rsp_digit_enable_n);
               mismatch_count++;
            end
            if (rsp_count_value !== want.count_value) begin
               $error("count_value: expected %0d, got %0d",
                      want.count_value, rsp_count_value);
               mismatch_count++;
            end
            if (rsp_save_strobe !== want.save_strobe) begin
               $error("save_strobe: expected %b, got %b",
                      want.save_strobe, rsp_save_strobe);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_tick(input logic up_n, input logic dn_n);
      button_tick_type t;
      t.up_n = up_n;
      t.dn_n = dn_n;
      button_ticks.push_back(t);
   endtask

   // Everything sent, everything back. Checked at the rising edge, where
   // the driver's state is stable.
   task automatic wait_idle();
      do @(posedge clock);
      while (button_ticks.size() != 0 || req_valid || expected_display.size() != 0);
   endtask

   // Register write; the local copy follows at the handshake edge.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         CSR_FILTER_LENGTH: begin
            cfg_filter_len = data[FILTER_W-1:0];
            up_filter_q    = cfg_filter_len;
            dn_filter_q    = cfg_filter_len;
         end
         CSR_DIGIT_HOLD: begin
            cfg_hold = data;
         end
         CSR_START_COUNT: begin
            // out-of-range start values load zero
            cfg_start = data[COUNT_W-1:0];
            count_q   = (cfg_start > COUNT_MAX) ? '0 : cfg_start;
         end
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly full presses (filter run-out, a few held ticks, release) of up with
   // random down, of down or of both; the rest is noise and presses cut short.
   task automatic queue_random(input int n);
      int pushed;
      int eff;
      int presses;
      int k;
      int pick;
      int which;
      pushed = 0;
      eff    = (cfg_filter_len == '0) ? 256 : int'(cfg_filter_len);
      while (pushed < n) begin
         pick = $urandom_range(99);
         if (pick < 90 && pick >= 75) begin
            presses = $urandom_range(5, 1);
            for (k = 0; k < presses; k++)
               push_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
         end else begin
            which   = $urandom_range(2);
            presses = (pick < 75) ? eff + $urandom_range(2)
                                  : $urandom_range(eff - 1);
            for (k = 0; k < presses; k++) begin
               if (which == 0)      push_tick(1'b0, 1'($urandom_range(1)));
               else if (which == 1) push_tick(1'b1, 1'b0);
               else                 push_tick(1'b0, 1'b0);
            end
            // release, sometimes with the other button sneaking in
            k = $urandom_range(3, 1);
            presses = presses + k;
            while (k > 0) begin
               push_tick(1'b1, ($urandom_range(9) == 0) ? 1'b0 : 1'b1);
               k--;
            end
         end
         pushed = pushed + presses;
      end
   endtask

   task automatic run_phase(input logic [CSR_DAT_W-1:0] filter_len,
                            input logic [CSR_DAT_W-1:0] hold,
                            input logic [CSR_DAT_W-1:0] start,
                            input int send_pct, input int recv_pct, input int n);
      wait_idle();
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      csr_write(CSR_FILTER_LENGTH, filter_len);
      csr_write(CSR_DIGIT_HOLD, hold);
      csr_write(CSR_START_COUNT, start);
      queue_random(n);
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin : run_test
      int k;
      seg_lut[0] = 8'hC0; seg_lut[1] = 8'hF9; seg_lut[2] = 8'hA4; seg_lut[3] = 8'hB0;
      seg_lut[4] = 8'h99; seg_lut[5] = 8'h92; seg_lut[6] = 8'h82; seg_lut[7] = 8'hF8;
      seg_lut[8] = 8'h80; seg_lut[9] = 8'h90;

      // state after reset
      cfg_filter_len = FILTER_RESET;
      cfg_hold       = HOLD_RESET;
      cfg_start      = START_RESET;
      count_q        = START_RESET;
      up_filter_q    = FILTER_RESET;
      dn_filter_q    = FILTER_RESET;
      up_wait_q      = 1'b0;
      dn_wait_q      = 1'b0;
      digit_q        = DIGIT_HUNDREDS;
      hold_q         = '0;
      shown_seg_q    = SEG_BLANK;
      shown_en_q     = EN_NONE;

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // default registers: scan from the first tick on; presses only
      // nibble at the long filter
      push_tick(1'b1, 1'b1);
      push_tick(1'b1, 1'b1);
      push_tick(1'b0, 1'b0);
      push_tick(1'b1, 1'b0);
      wait_idle();

      // short filter, fastest scan, count at the top
      csr_write(CSR_FILTER_LENGTH, 16'd2);
      csr_write(CSR_DIGIT_HOLD, 16'd1);
      csr_write(CSR_START_COUNT, 16'd999);
      push_tick(1'b0, 1'b1);    // up filter runs out
      push_tick(1'b0, 1'b1);
      push_tick(1'b0, 1'b0);    // held: waits, down ignored
      push_tick(1'b1, 1'b1);    // release: 999 wraps to 0
      push_tick(1'b1, 1'b0);    // down filter runs out
      push_tick(1'b1, 1'b0);
      push_tick(1'b0, 1'b0);    // down release pending: up not looked at
      push_tick(1'b0, 1'b1);    // release: 0 wraps to 999
      push_tick(1'b0, 1'b0);    // both: up wins
      push_tick(1'b0, 1'b0);
      push_tick(1'b1, 1'b0);    // up step and a down sample in one tick
      push_tick(1'b1, 1'b0);
      push_tick(1'b1, 1'b1);    // down step
      push_tick(1'b1, 1'b1);
      push_tick(1'b1, 1'b1);
      push_tick(1'b1, 1'b1);
      push_tick(1'b0, 1'b1);    // filter survives a bounce
      push_tick(1'b1, 1'b1);
      push_tick(1'b0, 1'b1);
      push_tick(1'b1, 1'b1);
      wait_idle();

      // unmapped register: nothing may change
      csr_write(CSR_UNUSED, 16'hFFFF);
      push_tick(1'b1, 1'b1);
      push_tick(1'b0, 1'b1);
      push_tick(1'b1, 1'b1);

      // sender rarely idle, receiver often stalled; one long hold-off
      // so the input side backs up while items keep coming
      run_phase(16'd1, 16'd1, 16'd500, 8, 59, 60);
      hold_off_req = 1'b1;
      // filter from the low byte only, zero hold, start above range
      run_phase(16'hFF03, 16'd0, 16'd1023, 8, 59, 60);

      // roles swapped
      run_phase(16'd4, 16'hFFFF, 16'd999, 59, 8, 60);
      // zero filter length wraps to 256 samples; hold lowered; one
      // complete press
      run_phase(16'd0, 16'd2, 16'd0, 59, 8, 0);
      for (k = 0; k < 258; k++) push_tick(1'b0, 1'($urandom_range(1)));
      push_tick(1'b1, 1'b1);
      push_tick(1'b1, 1'b1);
      push_tick(1'b1, 1'b1);

      // no idling from here on
      run_phase(16'd5, 16'd2, 16'd998, 0, 0, 40);
      // sender holds back until all results are in, then carries on
      wait_idle();
      queue_random(40);

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("[debounced_updown_counter_display] OK");
      else
         $display("[debounced_updown_counter_display] ERROR");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #400000;
      $display("[debounced_updown_counter_display] ERROR");
      $finish;
   end

endmodule

@@ debounced_updown_counter_display.f @@
rtl/duc_pkg.sv
rtl/debounced_updown_counter_display.sv
verif/debounced_updown_counter_display_tb.sv
